>>> hw/rtl/tmwheel_pkg.sv
`default_nettype none
package tmwheel_pkg;

	// default geometry
	localparam int TIMER_SLOTS_DEF      = 64;
	localparam int LEVEL0_BITS_DEF      = 8;
	localparam int UPPER_LEVEL_BITS_DEF = 6;
	localparam int LEVELS_DEF           = 5;

	// field widths
	localparam int CMD_W     = 2;
	localparam int TICKS_W   = 32;
	localparam int ID_W      = 32;
	localparam int PENDING_W = 7;
	localparam int S_DATA_W  = 64;
	localparam int M_DATA_W  = 40;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

	// result kinds
	localparam logic [CMD_W-1:0] KIND_SCHEDULE = 2'd0;
	localparam logic [CMD_W-1:0] KIND_CANCEL   = 2'd1;
	localparam logic [CMD_W-1:0] KIND_EXPIRED  = 2'd2;

	// status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

endpackage
`default_nettype wire

>>> hw/rtl/hierarchical_timer_wheel.sv
`default_nettype none
// Hierarchical timer wheel: a level 0 ring of 2^LEVEL0_BITS one-tick buckets and LEVELS-1
// upper rings of 2^UPPER_LEVEL_BITS buckets over a pool of TIMER_SLOTS timer slots. An item
// with s_tuser = schedule files a timer and answers with a fresh nonzero id (or status 1 and
// id 0 when the pool is full); cancel flags an id and answers whether this call cancelled it;
// tick advances time, cascades due upper buckets down and emits one item per live expired
// timer, tlast on the final one (no items when nothing expires). One sequencer with a single
// bucket-selection unit walks the lists one slot at a time, and the block takes no item while
// it works. After reset a clearing pass over max(NB, TIMER_SLOTS) entries (512 by default, NB
// the bucket count) initializes the bucket heads and the free chain before s_tready rises.
// Cancel searches the slots one at a time (up to TIMER_SLOTS); tick reads each cascaded level
// head, moves the timers in it, then drains the due level 0 bucket and emits its live timers,
// each step paced by the one-read-port bucket and slot memories.
module hierarchical_timer_wheel #(
	parameter int TIMER_SLOTS      = tmwheel_pkg::TIMER_SLOTS_DEF,
	parameter int LEVEL0_BITS      = tmwheel_pkg::LEVEL0_BITS_DEF,
	parameter int UPPER_LEVEL_BITS = tmwheel_pkg::UPPER_LEVEL_BITS_DEF,
	parameter int LEVELS           = tmwheel_pkg::LEVELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [tmwheel_pkg::S_DATA_W-1:0] s_tdata,  // delay_ticks[31:0], task_id[63:32]
	input  wire logic [tmwheel_pkg::CMD_W-1:0]   s_tuser,  // command[1:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [tmwheel_pkg::M_DATA_W-1:0]     m_tdata,  // timer_id[31:0], status[32], pending[39:33]
	output logic [tmwheel_pkg::CMD_W-1:0]        m_tuser,  // kind[1:0]
	output logic                                 m_tlast
);

	localparam int SI       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int SLOT_W   = $clog2(TIMER_SLOTS + 1);
	localparam int L0_SIZE  = 1 << LEVEL0_BITS;
	localparam int UP_SIZE  = 1 << UPPER_LEVEL_BITS;
	localparam int NB       = L0_SIZE + (LEVELS - 1) * UP_SIZE;
	localparam int BW       = $clog2(NB);
	localparam int TOTAL_BITS = LEVEL0_BITS + (LEVELS - 1) * UPPER_LEVEL_BITS;
	localparam int CLR_N    = (NB > TIMER_SLOTS) ? NB : TIMER_SLOTS;
	localparam int CW       = $clog2(CLR_N);
	localparam int LVW      = $clog2(LEVELS);
	localparam int TW       = tmwheel_pkg::TICKS_W;
	localparam int IW       = tmwheel_pkg::ID_W;
	localparam int PW       = tmwheel_pkg::PENDING_W;
	localparam logic [SLOT_W-1:0] NIL = SLOT_W'(TIMER_SLOTS);
	localparam logic [TW-1:0] MAX_DELAY =
		(TOTAL_BITS < 32) ? TW'((64'd1 << TOTAL_BITS) - 64'd1) : {TW{1'b1}};

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RESULT,
		ST_SCH_RD, ST_SCH_HEAD, ST_SCH_WR,
		ST_CAN_RD, ST_CAN_CMP,
		ST_CAS_HEAD, ST_CAS_HEAD2, ST_CAS_NODE, ST_CAS_CALC, ST_CAS_WR,
		ST_DRN_HEAD, ST_DRN_HEAD2, ST_DRN_NODE, ST_DRN_STEP,
		ST_EMIT_RD, ST_EMIT
	} state_t;

	// bucket of a timer filed with this delta and expiry
	function automatic logic [BW-1:0] file_bucket(input logic [TW-1:0] delta,
	                                              input logic [TW-1:0] target);
		logic [LVW-1:0] lv;
		logic [63:0]    tmp;
		logic [BW-1:0]  res;
		lv  = LVW'(LEVELS - 1);
		for (int k = LEVELS - 2; k >= 0; k--) begin
			if ({32'b0, delta} < (64'd1 << (LEVEL0_BITS + k * UPPER_LEVEL_BITS)))
				lv = LVW'(k);
		end
		res = BW'(target[LEVEL0_BITS-1:0]);
		for (int k = 1; k < LEVELS; k++) begin
			if (lv == LVW'(k)) begin
				tmp = {32'b0, target} >> (LEVEL0_BITS + (k - 1) * UPPER_LEVEL_BITS);
				res = BW'(L0_SIZE + (k - 1) * UP_SIZE) + BW'(tmp[UPPER_LEVEL_BITS-1:0]);
			end
		end
		return res;
	endfunction

	// ring index of an upper level at tick t
	function automatic logic [UPPER_LEVEL_BITS-1:0] up_index(input logic [LVW-1:0] lv,
	                                                         input logic [TW-1:0] t);
		logic [63:0]                 tmp;
		logic [UPPER_LEVEL_BITS-1:0] res;
		res = '0;
		for (int k = 1; k < LEVELS; k++) begin
			if (lv == LVW'(k)) begin
				tmp = {32'b0, t} >> (LEVEL0_BITS + (k - 1) * UPPER_LEVEL_BITS);
				res = tmp[UPPER_LEVEL_BITS-1:0];
			end
		end
		return res;
	endfunction

	state_t state_q;

	// memories
	logic [SLOT_W-1:0] head_mem [NB];
	logic [SLOT_W-1:0] link_mem [TIMER_SLOTS];
	logic [TW-1:0]     exp_mem  [TIMER_SLOTS];
	logic [IW-1:0]     id_mem   [TIMER_SLOTS];
	logic [IW-1:0]     ob_mem   [TIMER_SLOTS];
	logic [SLOT_W-1:0] head_rd_q, link_rd_q;
	logic [TW-1:0]     exp_rd_q;
	logic [IW-1:0]     id_rd_q, ob_rd_q;

	logic              head_we, link_we, slot_we, ob_we;
	logic [BW-1:0]     head_ra, head_wa;
	logic [SLOT_W-1:0] head_wd, link_wd;
	logic [SI-1:0]     link_wa, slot_ra, ob_wa;

	// control and bookkeeping
	logic [CW-1:0]     clr_q;
	logic [SLOT_W-1:0] fh_q, n_q, nx_q, cnt_q;
	logic [SI-1:0]     s_q, i_q, ei_q;
	logic [BW-1:0]     b_q;
	logic [LVW-1:0]    lvl_q;
	logic [TW-1:0]     tick_q, dly_q;
	logic [IW-1:0]     nid_q, task_q;
	logic [PW-1:0]     pending_q;
	logic [TIMER_SLOTS-1:0] busy_q, cancel_q;
	logic [tmwheel_pkg::CMD_W-1:0] res_kind_q;
	logic [IW-1:0]     res_id_q;
	logic              res_st_q;

	logic              in_acc, out_free, out_load;
	logic [TW-1:0]     in_delay, dly_fix, tick_nx, fb_delta, fb_target;
	logic [IW-1:0]     in_task, nid_nx;
	logic [BW-1:0]     fb, cas_b, drn_b;
	logic [UPPER_LEVEL_BITS-1:0] cas_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	// output register takes a new item this cycle
	assign out_load = out_free && (state_q == ST_RESULT || state_q == ST_EMIT);
	assign in_delay = s_tdata[TW-1:0];
	assign in_task  = s_tdata[TW+IW-1:TW];
	assign tick_nx  = tick_q + TW'(1);
	assign nid_nx   = (nid_q + IW'(1) == '0) ? IW'(1) : nid_q + IW'(1);

	always_comb begin
		dly_fix = (in_delay > MAX_DELAY) ? MAX_DELAY : in_delay;
		if (dly_fix == '0)
			dly_fix = TW'(1);
	end

	// shared bucket selection: cascade refile or schedule
	always_comb begin
		if (state_q == ST_CAS_CALC) begin
			fb_delta  = exp_rd_q - tick_q;
			fb_target = exp_rd_q;
		end else begin
			fb_delta  = dly_q;
			fb_target = tick_q + dly_q;
		end
	end
	assign fb      = file_bucket(fb_delta, fb_target);
	assign cas_idx = up_index(lvl_q, tick_q);
	assign cas_b   = BW'(L0_SIZE) + BW'(lvl_q - LVW'(1)) * BW'(UP_SIZE) + BW'(cas_idx);
	assign drn_b   = BW'(tick_q[LEVEL0_BITS-1:0]);

	// memory port steering
	always_comb begin
		head_ra = '0;
		head_we = 1'b0;
		head_wa = '0;
		head_wd = NIL;
		link_we = 1'b0;
		link_wa = n_q[SI-1:0];
		link_wd = NIL;
		slot_ra = n_q[SI-1:0];
		slot_we = 1'b0;
		ob_we   = 1'b0;
		ob_wa   = cnt_q[SI-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				head_we = (int'(clr_q) < NB);
				head_wa = BW'(clr_q);
				link_we = (int'(clr_q) < TIMER_SLOTS);
				link_wa = SI'(clr_q);
				link_wd = SLOT_W'(clr_q) + SLOT_W'(1);
			end
			ST_SCH_RD:   slot_ra = fh_q[SI-1:0];
			ST_SCH_HEAD: begin
				head_ra = fb;
				slot_we = 1'b1;
			end
			ST_SCH_WR: begin
				link_we = 1'b1;
				link_wa = s_q;
				link_wd = head_rd_q;
				head_we = 1'b1;
				head_wa = b_q;
				head_wd = SLOT_W'(s_q);
			end
			ST_CAN_RD:    slot_ra = i_q;
			ST_CAS_HEAD:  head_ra = cas_b;
			ST_CAS_HEAD2: begin
				head_we = 1'b1;
				head_wa = cas_b;
			end
			ST_CAS_CALC:  head_ra = fb;
			ST_CAS_WR: begin
				link_we = 1'b1;
				link_wd = head_rd_q;
				head_we = 1'b1;
				head_wa = b_q;
				head_wd = n_q;
			end
			ST_DRN_HEAD:  head_ra = drn_b;
			ST_DRN_HEAD2: begin
				head_we = 1'b1;
				head_wa = drn_b;
			end
			ST_DRN_STEP: begin
				link_we = 1'b1;
				link_wd = fh_q;
				ob_we   = !cancel_q[n_q[SI-1:0]];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			exp_mem[s_q] <= tick_q + dly_q;
			id_mem[s_q]  <= nid_q;
		end
		exp_rd_q <= exp_mem[slot_ra];
		id_rd_q  <= id_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (ob_we)
			ob_mem[ob_wa] <= id_rd_q;
		ob_rd_q <= ob_mem[ei_q];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			fh_q       <= '0;
			n_q        <= NIL;
			nx_q       <= NIL;
			cnt_q      <= '0;
			s_q        <= '0;
			i_q        <= '0;
			ei_q       <= '0;
			b_q        <= '0;
			lvl_q      <= '0;
			tick_q     <= '0;
			dly_q      <= '0;
			nid_q      <= IW'(1);
			task_q     <= '0;
			pending_q  <= '0;
			busy_q     <= '0;
			cancel_q   <= '0;
			res_kind_q <= tmwheel_pkg::KIND_SCHEDULE;
			res_id_q   <= '0;
			res_st_q   <= tmwheel_pkg::STATUS_OK;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= '0;
			m_tlast    <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							tmwheel_pkg::CMD_SCHEDULE: begin
								res_kind_q <= tmwheel_pkg::KIND_SCHEDULE;
								if (fh_q == NIL) begin
									res_id_q <= '0;
									res_st_q <= tmwheel_pkg::STATUS_FAIL;
									state_q  <= ST_RESULT;
								end else begin
									s_q     <= fh_q[SI-1:0];
									dly_q   <= dly_fix;
									state_q <= ST_SCH_RD;
								end
							end
							tmwheel_pkg::CMD_CANCEL: begin
								res_kind_q <= tmwheel_pkg::KIND_CANCEL;
								res_id_q   <= in_task;
								task_q     <= in_task;
								i_q        <= '0;
								if (in_task == '0) begin
									res_st_q <= tmwheel_pkg::STATUS_FAIL;
									state_q  <= ST_RESULT;
								end else begin
									state_q <= ST_CAN_RD;
								end
							end
							tmwheel_pkg::CMD_TICK: begin
								tick_q <= tick_nx;
								lvl_q  <= LVW'(1);
								if (tick_nx[LEVEL0_BITS-1:0] == '0)
									state_q <= ST_CAS_HEAD;
								else
									state_q <= ST_DRN_HEAD;
							end
							default: ;
						endcase
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_tuser  <= res_kind_q;
						m_tdata  <= {pending_q, res_st_q, res_id_q};
						m_tlast  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_SCH_RD: state_q <= ST_SCH_HEAD;
				ST_SCH_HEAD: begin
					fh_q    <= link_rd_q;
					b_q     <= fb;
					state_q <= ST_SCH_WR;
				end
				ST_SCH_WR: begin
					busy_q[s_q]   <= 1'b1;
					cancel_q[s_q] <= 1'b0;
					pending_q     <= pending_q + PW'(1);
					res_id_q      <= nid_q;
					res_st_q      <= tmwheel_pkg::STATUS_OK;
					nid_q         <= nid_nx;
					state_q       <= ST_RESULT;
				end
				ST_CAN_RD: state_q <= ST_CAN_CMP;
				ST_CAN_CMP: begin
					if (busy_q[i_q] && id_rd_q == task_q) begin
						cancel_q[i_q] <= 1'b1;
						res_st_q      <= cancel_q[i_q];
						state_q       <= ST_RESULT;
					end else if (i_q == SI'(TIMER_SLOTS - 1)) begin
						res_st_q <= tmwheel_pkg::STATUS_FAIL;
						state_q  <= ST_RESULT;
					end else begin
						i_q     <= i_q + SI'(1);
						state_q <= ST_CAN_RD;
					end
				end
				ST_CAS_HEAD:  state_q <= ST_CAS_HEAD2;
				ST_CAS_HEAD2: begin
					n_q     <= head_rd_q;
					state_q <= ST_CAS_NODE;
				end
				ST_CAS_NODE: begin
					if (n_q == NIL) begin
						// stop at the first level whose ring did not wrap
						if (cas_idx != '0 || lvl_q == LVW'(LEVELS - 1)) begin
							state_q <= ST_DRN_HEAD;
						end else begin
							lvl_q   <= lvl_q + LVW'(1);
							state_q <= ST_CAS_HEAD;
						end
					end else begin
						state_q <= ST_CAS_CALC;
					end
				end
				ST_CAS_CALC: begin
					nx_q    <= link_rd_q;
					b_q     <= fb;
					state_q <= ST_CAS_WR;
				end
				ST_CAS_WR: begin
					n_q     <= nx_q;
					state_q <= ST_CAS_NODE;
				end
				ST_DRN_HEAD:  state_q <= ST_DRN_HEAD2;
				ST_DRN_HEAD2: begin
					n_q     <= head_rd_q;
					cnt_q   <= '0;
					state_q <= ST_DRN_NODE;
				end
				ST_DRN_NODE: begin
					if (n_q == NIL) begin
						ei_q <= '0;
						if (cnt_q == '0)
							state_q <= ST_IDLE;
						else
							state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_DRN_STEP;
					end
				end
				ST_DRN_STEP: begin
					if (pending_q != '0)
						pending_q <= pending_q - PW'(1);
					if (!cancel_q[n_q[SI-1:0]])
						cnt_q <= cnt_q + SLOT_W'(1);
					busy_q[n_q[SI-1:0]]   <= 1'b0;
					cancel_q[n_q[SI-1:0]] <= 1'b0;
					fh_q    <= n_q;
					n_q     <= link_rd_q;
					state_q <= ST_DRN_NODE;
				end
				ST_EMIT_RD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						m_tuser  <= tmwheel_pkg::KIND_EXPIRED;
						m_tdata  <= {pending_q, tmwheel_pkg::STATUS_OK, ob_rd_q};
						m_tlast  <= (SLOT_W'(ei_q) + SLOT_W'(1) == cnt_q);
						if (SLOT_W'(ei_q) + SLOT_W'(1) == cnt_q) begin
							state_q <= ST_IDLE;
						end else begin
							ei_q    <= ei_q + SI'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/hierarchical_timer_wheel_tb.sv
module hierarchical_timer_wheel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// default geometry of the wheel under test
	localparam int SLOTS    = tmwheel_pkg::TIMER_SLOTS_DEF;
	localparam int L0_BITS  = tmwheel_pkg::LEVEL0_BITS_DEF;
	localparam int UP_BITS  = tmwheel_pkg::UPPER_LEVEL_BITS_DEF;
	localparam int NLEVELS  = tmwheel_pkg::LEVELS_DEF;
	localparam int L0_SIZE  = 1 << L0_BITS;
	localparam int UP_SIZE  = 1 << UP_BITS;
	localparam int NBUCKETS = L0_SIZE + (NLEVELS - 1) * UP_SIZE;
	localparam int SPAN_BITS = L0_BITS + (NLEVELS - 1) * UP_BITS;
	localparam int NIL      = SLOTS;
	localparam int STALL_MAX = 17;
	localparam int CMD_W     = tmwheel_pkg::CMD_W;
	localparam int PENDING_W = tmwheel_pkg::PENDING_W;
	// command code the block ignores
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	// no accepted item for this many cycles means the block hung; covers the
	// clearing pass after reset and a worst case tick walk with stalls
	localparam int WATCHDOG_LIMIT = 60000;

	typedef struct packed {
		logic [CMD_W-1:0]                  command;
		logic [tmwheel_pkg::TICKS_W-1:0]   delay_ticks;
		logic [tmwheel_pkg::ID_W-1:0]      task_id;
	} wheel_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]                  kind;
		logic [tmwheel_pkg::ID_W-1:0]      timer_id;
		logic                              status;
		logic [PENDING_W-1:0]              pending;
		logic                              last;
	} wheel_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tmwheel_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tmwheel_pkg::M_DATA_W-1:0] m_tdata;
	logic [CMD_W-1:0] m_tuser;
	logic m_tlast;

	hierarchical_timer_wheel dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Shadow wheel: own copy of slot pool, buckets and clock
	// ---------------------------------------------------------------------
	logic [31:0] sh_expiry [SLOTS];
	logic [31:0] sh_ident  [SLOTS];
	int          sh_link   [SLOTS];
	bit          sh_cancel [SLOTS];
	bit          sh_busy   [SLOTS];
	int          sh_bucket [NBUCKETS];
	int          sh_free;
	logic [31:0] sh_now;
	logic [31:0] sh_next_id;
	int          sh_pending;

	wheel_resp_t expected_results[$];
	wheel_cmd_t  pending_cmds[$];

	int mismatches = 0;
	bit hold_for_drain = 0; // sender pause until the result queue is empty

	function automatic void push_expected(wheel_resp_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic void wheel_reset();
		for (int i = 0; i < SLOTS; i++) begin
			sh_link[i] = i + 1;
			sh_cancel[i] = 0;
			sh_busy[i] = 0;
			sh_expiry[i] = '0;
			sh_ident[i] = '0;
		end
		for (int i = 0; i < NBUCKETS; i++) sh_bucket[i] = NIL;
		sh_free = 0;
		sh_now = '0;
		sh_next_id = 32'd1;
		sh_pending = 0;
	endfunction

	function automatic int bucket_at(int level, logic [31:0] t);
		logic [63:0] wide;
		wide = {32'd0, t};
		if (level == 0) return int'(t[L0_BITS-1:0]);
		return L0_SIZE + (level - 1) * UP_SIZE
			+ int'((wide >> (L0_BITS + (level - 1) * UP_BITS)) & (UP_SIZE - 1));
	endfunction

	function automatic void file_timer(int s, logic [31:0] delta);
		int lvl;
		int b;
		lvl = 0;
		while (lvl + 1 < NLEVELS && {32'd0, delta} >= (64'd1 << (L0_BITS + lvl * UP_BITS)))
			lvl++;
		b = bucket_at(lvl, sh_now + delta);
		sh_link[s] = sh_bucket[b];
		sh_bucket[b] = s;
	endfunction

	// compute the results one command causes and append them to the queue
	function automatic void predict_wheel(wheel_cmd_t c);
		wheel_resp_t r;
		logic [31:0] d;
		int s, n, nx, b, first, cnt;
		r = '0;
		r.last = 1'b1;
		case (c.command)
			tmwheel_pkg::CMD_SCHEDULE: begin
				r.kind = tmwheel_pkg::KIND_SCHEDULE;
				if (sh_free >= SLOTS) begin
					r.status = tmwheel_pkg::STATUS_FAIL;
					r.pending = PENDING_W'(sh_pending);
					push_expected(r);
				end else begin
					d = c.delay_ticks;
					if (SPAN_BITS < 32 && {32'd0, d} > (64'd1 << SPAN_BITS) - 1)
						d = 32'((64'd1 << SPAN_BITS) - 1);
					if (d == 0) d = 32'd1;
					s = sh_free;
					sh_free = sh_link[s];
					sh_ident[s] = sh_next_id;
					r.timer_id = sh_next_id;
					sh_next_id++;
					if (sh_next_id == 0) sh_next_id = 32'd1;
					sh_expiry[s] = sh_now + d;
					sh_cancel[s] = 0;
					sh_busy[s] = 1;
					sh_pending++;
					file_timer(s, d);
					r.status = tmwheel_pkg::STATUS_OK;
					r.pending = PENDING_W'(sh_pending);
					push_expected(r);
				end
			end
			tmwheel_pkg::CMD_CANCEL: begin
				r.kind = tmwheel_pkg::KIND_CANCEL;
				r.timer_id = c.task_id;
				r.status = tmwheel_pkg::STATUS_FAIL;
				if (c.task_id != 0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (sh_busy[i] && sh_ident[i] == c.task_id) begin
							if (!sh_cancel[i]) begin
								sh_cancel[i] = 1;
								r.status = tmwheel_pkg::STATUS_OK;
							end
							break;
						end
					end
				end
				r.pending = PENDING_W'(sh_pending);
				push_expected(r);
			end
			tmwheel_pkg::CMD_TICK: begin
				sh_now++;
				if (sh_now[L0_BITS-1:0] == 0) begin
					for (int k = 1; k < NLEVELS; k++) begin
						b = bucket_at(k, sh_now);
						n = sh_bucket[b];
						sh_bucket[b] = NIL;
						while (n < SLOTS) begin
							nx = sh_link[n];
							file_timer(n, sh_expiry[n] - sh_now);
							n = nx;
						end
						if (b != L0_SIZE + (k - 1) * UP_SIZE) break;
					end
				end
				b = bucket_at(0, sh_now);
				n = sh_bucket[b];
				sh_bucket[b] = NIL;
				first = expected_results.size();
				cnt = 0;
				while (n < SLOTS) begin
					nx = sh_link[n];
					if (sh_pending > 0) sh_pending--;
					if (!sh_cancel[n]) begin
						r = '0;
						r.kind = tmwheel_pkg::KIND_EXPIRED;
						r.timer_id = sh_ident[n];
						r.status = tmwheel_pkg::STATUS_OK;
						push_expected(r);
						cnt++;
					end
					sh_busy[n] = 0;
					sh_cancel[n] = 0;
					sh_link[n] = sh_free;
					sh_free = n;
					n = nx;
				end
				// pending is the count after the whole drain
				for (int k = first; k < first + cnt; k++) begin
					expected_results[k].pending = PENDING_W'(sh_pending);
					expected_results[k].last = (k == first + cnt - 1);
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Driver: one item from pending_cmds per handshake, random gaps
	// ---------------------------------------------------------------------
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_wheel({s_tuser, s_tdata[31:0], s_tdata[63:32]});
			if (s_tvalid && !s_tready) begin
				// hold the item
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0
					&& !(hold_for_drain && expected_results.size() > 0)) begin
				wheel_cmd_t c;
				c = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= c.command;
				s_tdata <= {c.task_id, c.delay_ticks};
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: compares each accepted result with the oldest expectation
	// ---------------------------------------------------------------------
	int recv_gap = 0;
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				wheel_resp_t got, exp_r;
				got.kind = m_tuser;
				got.timer_id = m_tdata[31:0];
				got.status = m_tdata[32];
				got.pending = m_tdata[39:33];
				got.last = m_tlast;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d id=%0h", got.kind, got.timer_id);
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch exp kind=%0d id=%0h st=%0d pend=%0d last=%0d"
								, exp_r.kind, exp_r.timer_id, exp_r.status, exp_r.pending,
								exp_r.last, " got kind=%0d id=%0h st=%0d pend=%0d last=%0d",
								got.kind, got.timer_id, got.status, got.pending, got.last);
					end
				end
				recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, STALL_MAX);
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	int total_items = 0;

	function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [31:0] d, logic [31:0] id);
		wheel_cmd_t c;
		c.command = cmd;
		c.delay_ticks = d;
		c.task_id = id;
		pending_cmds = {pending_cmds, c};
		total_items++;
	endfunction

	// random delay, mostly short so timers expire within the run
	function automatic logic [31:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();
			2: return $urandom_range(L0_SIZE - 2, L0_SIZE + 40);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	initial begin
		logic [31:0] next_guess;
		wheel_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero delay, saturated delay, cancel cases
		add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);            // empty tick
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd0, 32'hFFFF_FFFF); // zero delay fires next tick
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'hFFFF_FFFF, 32'd0); // saturates at span
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd1, 32'd0);
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd3, 32'd0);
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd2, 32'd0);
		add_cmd(tmwheel_pkg::CMD_CANCEL, 32'd0, 32'd0);           // id zero is never valid
		add_cmd(tmwheel_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 32'd4);   // live timer
		add_cmd(tmwheel_pkg::CMD_CANCEL, 32'd0, 32'd4);           // already cancelled
		add_cmd(tmwheel_pkg::CMD_CANCEL, 32'd0, 32'hFFFF_FFFF);   // not found
		add_cmd(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // unknown command ignored
		add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);
		add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);
		add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);             // cancelled one drained silently
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd256, 32'd0);       // level 1
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd300, 32'd0);
		add_cmd(tmwheel_pkg::CMD_SCHEDULE, 32'd16384, 32'd0);     // level 2
		next_guess = 32'd10;
		// fill the pool past its end: pool full answers
		for (int i = 0; i < SLOTS; i++)
			add_cmd(tmwheel_pkg::CMD_SCHEDULE, $urandom_range(1, 8), 32'd0);
		while (pending_cmds.size() > 0 || expected_results.size() > 0 || s_tvalid)
			@(posedge clk);
		// drain most of it
		for (int i = 0; i < 10; i++) add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);

		// random part: schedules, cancels of live and stale ids, ticks, noise
		while (total_items < 160) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6:
					add_cmd(tmwheel_pkg::CMD_SCHEDULE, pick_delay(), $urandom());
				7, 8, 9: add_cmd(tmwheel_pkg::CMD_CANCEL, $urandom(),
					$urandom_range(0, 7) == 0 ? $urandom() : next_guess - $urandom_range(0, 30));
				10: add_cmd(CMD_UNKNOWN, $urandom(), $urandom());
				default: add_cmd(tmwheel_pkg::CMD_TICK, $urandom(), $urandom());
			endcase
			if (pending_cmds[$].command == tmwheel_pkg::CMD_SCHEDULE) next_guess++;
			if (total_items == 125) begin
				// from here on the sender waits until every result is in before each item
				while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
				hold_for_drain = 1;
			end
		end
		// a run of ticks so pending timers fire
		for (int i = 0; i < 50; i++) add_cmd(tmwheel_pkg::CMD_TICK, 32'd0, 32'd0);
		while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
		hold_for_drain = 0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog: ends a hung run
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/tmwheel_pkg.sv
hw/rtl/hierarchical_timer_wheel.sv
tb/sv/hierarchical_timer_wheel_tb.sv
